// File: rtl/fwcbk_pkg.sv
// Shared package for the keyed-removal order queue: field widths, command and
// status codes, the entry record and the per-cell control group.
// No dependencies; used by fwcbk_cell and fifo_with_cancel_by_key.
`default_nettype none

package fwcbk_pkg;

    localparam int DEF_DEPTH = 128;

    localparam int CMD_W   = 2;
    localparam int NAME_W  = 64;
    localparam int PHONE_W = 50;
    localparam int CODE_W  = 64;
    localparam int QTY_W   = 16;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 8;

    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 208;
    localparam int S_PAD_W  = S_DATA_W - (CMD_W + NAME_W + PHONE_W + CODE_W + QTY_W);
    localparam int M_PAD_W  = M_DATA_W - (STAT_W + NAME_W + PHONE_W + CODE_W + QTY_W + OCC_W);

    // Command codes; the remaining code is ignored and answered with an ok status.
    localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [QTY_W-1:0]   qty;
        logic [CODE_W-1:0]  code;
        logic [PHONE_W-1:0] phone;
        logic [NAME_W-1:0]  name;
    } entry_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic push;    // write the new entry into the tail cell
        logic pop;     // every cell takes its upper neighbour's entry
        logic track;   // the search token moves one cell up
        logic remove;  // cells at and above the token take their upper neighbour's entry
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fwcbk_cell.sv
// One cell of the queue row: holds a single entry and the search token flags.
// Depends on fwcbk_pkg for the entry record and the control group.
`default_nettype none

module fwcbk_cell
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  fwcbk_pkg::cell_ctl_t   ctl,
    input  wire                    occ,        // this cell holds a live entry
    input  wire                    tail,       // this cell is the first free place
    input  fwcbk_pkg::entry_t      new_entry,  // entry of the command under way
    input  fwcbk_pkg::entry_t      nxt_entry,  // entry of the upper neighbour
    input  wire                    tok_in,     // token handed on by the lower neighbour
    output fwcbk_pkg::entry_t      entry,
    output logic                   tok,
    output logic                   found
);

    fwcbk_pkg::entry_t entry_reg;
    fwcbk_pkg::entry_t entry_next;
    logic              tok_reg;
    logic              tok_next;
    logic              passed_reg;
    logic              passed_next;

    // The token stops at the first live entry whose name and phone both match.
    assign found = tok_reg & occ
                 & (entry_reg.name == new_entry.name)
                 & (entry_reg.phone == new_entry.phone);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.pop || (ctl.remove && !passed_reg))
        begin
            entry_next = nxt_entry;
        end
        else if (ctl.push && tail)
        begin
            entry_next = new_entry;
        end
    end

    // A cell the token has already left keeps its entry on removal.
    assign tok_next    = ctl.track & tok_in;
    assign passed_next = ctl.track & (passed_reg | tok_reg);

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            passed_reg <= passed_next;
        end
    end

    assign entry = entry_reg;
    assign tok   = tok_reg;

endmodule

`default_nettype wire

// File: rtl/fifo_with_cancel_by_key.sv
// Keyed-removal order queue: enqueue and dequeue act in the execute state, and the result is
// registered once the output register is free. Cancel launches a search token that walks the
// cell row one cell per cycle until it stops on a match or passes the last held entry. One
// command is in work at a time; a result may wait at the output while the next command beat is
// taken. Reset clears the count and the control state; entry storage is not cleared and needs
// no clearing pass.
// Depends on fwcbk_pkg and fwcbk_cell.
`default_nettype none

module fifo_with_cancel_by_key
#(
    parameter int DEPTH = fwcbk_pkg::DEF_DEPTH
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // From bit 0: cmd[2], key_name[64], key_phone[50], product_code[64], quantity[16], zeros[4]
    input  wire  [fwcbk_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // From bit 0: status[2], out_name[64], out_phone[50], out_code[64], out_quantity[16],
    // occupancy[8], zeros[4]
    output logic [fwcbk_pkg::M_DATA_W-1:0] m_tdata
);

    // The count must hold DEPTH itself, so it is $clog2(DEPTH + 1) bits wide.
    localparam int              CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);

    fwcbk_pkg::state_t      state_reg;
    fwcbk_pkg::state_t      state_next;
    logic [fwcbk_pkg::CMD_W-1:0] cmd_reg;
    logic [fwcbk_pkg::CMD_W-1:0] cmd_next;
    fwcbk_pkg::entry_t      in_reg;
    fwcbk_pkg::entry_t      in_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          scan_cnt_reg;
    logic [CW-1:0]          scan_cnt_next;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    fwcbk_pkg::status_t     res_status_reg;
    fwcbk_pkg::status_t     res_status_next;
    fwcbk_pkg::entry_t      res_entry_reg;
    fwcbk_pkg::entry_t      res_entry_next;
    logic [fwcbk_pkg::OCC_W-1:0] res_occ_reg;
    logic [fwcbk_pkg::OCC_W-1:0] res_occ_next;

    fwcbk_pkg::cell_ctl_t   ctl;
    logic                   start;
    logic                   load_res;
    logic                   res_deq;
    fwcbk_pkg::status_t     res_status;

    fwcbk_pkg::entry_t      cell_entry [DEPTH];
    logic [DEPTH-1:0]       tok_vec;
    logic [DEPTH-1:0]       found_vec;
    logic [DEPTH-1:0]       occ_vec;
    logic [DEPTH-1:0]       tail_vec;
    logic                   found_any;
    logic                   out_free;

    // The result register is free when empty or when its beat is taken this cycle.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign found_any = |found_vec;
    assign s_tready  = (state_reg == fwcbk_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // The cell row. Entry 0 is the oldest; removal pulls the upper
    // neighbour's entry down, and the search token climbs from cell 0.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic              tok_in;
        fwcbk_pkg::entry_t nxt_entry;

        assign occ_vec[i]  = (IDX < count_reg);
        assign tail_vec[i] = (IDX == count_reg);

        if (i == 0)
        begin : g_first
            assign tok_in = start;
        end
        else
        begin : g_inner
            assign tok_in = tok_vec[i-1] & ~found_vec[i-1];
        end

        // The top cell is never read after it is vacated, so any entry will do.
        if (i == DEPTH - 1)
        begin : g_top
            assign nxt_entry = in_reg;
        end
        else
        begin : g_below
            assign nxt_entry = cell_entry[i+1];
        end

        fwcbk_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .occ       (occ_vec[i]),
            .tail      (tail_vec[i]),
            .new_entry (in_reg),
            .nxt_entry (nxt_entry),
            .tok_in    (tok_in),
            .entry     (cell_entry[i]),
            .tok       (tok_vec[i]),
            .found     (found_vec[i])
        );
    end

    // ------------------------------------------------------------------
    // Command sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwcbk_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = fwcbk_pkg::ST_EXEC;
                end
            end
            fwcbk_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    if (cmd_reg == fwcbk_pkg::CMD_CANCEL)
                    begin
                        state_next = fwcbk_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fwcbk_pkg::ST_IDLE;
                    end
                end
            end
            fwcbk_pkg::ST_SCAN:
            begin
                if (found_any || (scan_cnt_reg == count_reg))
                begin
                    state_next = fwcbk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwcbk_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Command sequencer: outputs. Enqueue and dequeue act in the execute
    // state once the output register is free; cancel launches the token
    // and then waits in the scan state until it stops on a match or
    // passes the last held entry. The output register stays empty for
    // the whole scan, since only this sequencer fills it.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl           = '0;
        start         = 1'b0;
        load_res      = 1'b0;
        res_deq       = 1'b0;
        res_status    = fwcbk_pkg::STAT_OK;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            fwcbk_pkg::ST_IDLE:
            begin
            end
            fwcbk_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    case (cmd_reg)
                        fwcbk_pkg::CMD_ENQ:
                        begin
                            load_res = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                res_status = fwcbk_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.push   = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fwcbk_pkg::CMD_DEQ:
                        begin
                            load_res = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = fwcbk_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ctl.pop    = 1'b1;
                                res_deq    = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        fwcbk_pkg::CMD_CANCEL:
                        begin
                            start         = 1'b1;
                            ctl.track     = 1'b1;
                            scan_cnt_next = '0;
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            fwcbk_pkg::ST_SCAN:
            begin
                if (found_any)
                begin
                    ctl.remove = 1'b1;
                    load_res   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else if (scan_cnt_reg == count_reg)
                begin
                    load_res   = 1'b1;
                    res_status = fwcbk_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    ctl.track     = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Command capture.
    always_comb
    begin
        cmd_next = cmd_reg;
        in_next  = in_reg;
        if (s_tvalid && s_tready)
        begin
            cmd_next       = s_tdata[1:0];
            in_next.name   = s_tdata[65:2];
            in_next.phone  = s_tdata[115:66];
            in_next.code   = s_tdata[179:116];
            in_next.qty    = s_tdata[195:180];
        end
    end

    // Result register: only a dequeue that found an entry reports its fields.
    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_occ_next    = res_occ_reg;
        if (load_res)
        begin
            m_tvalid_next   = 1'b1;
            res_status_next = res_status;
            res_entry_next  = res_deq ? cell_entry[0] : '0;
            res_occ_next    = fwcbk_pkg::OCC_W'(count_next);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fwcbk_pkg::ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        in_reg         <= in_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_occ_reg    <= res_occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{fwcbk_pkg::M_PAD_W{1'b0}}, res_occ_reg, res_entry_reg.qty,
                       res_entry_reg.code, res_entry_reg.phone, res_entry_reg.name,
                       res_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds the queue depth");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the cell row");

    a_found_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        found_any |-> (state_reg == fwcbk_pkg::ST_SCAN))
        else $error("match reported outside a cancel search");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fwcbk_pkg::ST_EXEC && out_free && cmd_reg == fwcbk_pkg::CMD_DEQ
         && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("dequeue did not lower the count by one");

    a_token_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fwcbk_pkg::ST_IDLE) |-> (tok_vec == '0))
        else $error("search token left in the row while idle");

endmodule

`default_nettype wire
